// ===== design/rpvg_pkg.sv =====
package rpvg_pkg;

  localparam int MAX_SIDES_DEF = 64;
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [1:0] REG_GRID_SCALE = 2'd0;
  localparam logic [1:0] REG_ORIGIN_X   = 2'd1;
  localparam logic [1:0] REG_ORIGIN_Y   = 2'd2;

  localparam logic [15:0] GRID_SCALE_RST = 16'd256;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] SINE_SEED = 32'd3864;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] corner_x;
    logic signed [31:0] corner_y;
    logic [6:0]         side_count;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [5:0]         vertex_index;
    logic               last_vertex;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQA, ST_SQB, ST_ROOT, ST_DIV, ST_TRIG,
    ST_OFFX, ST_OFFY, ST_SCX, ST_SCY, ST_EMIT
  } state_t;

  // Horner coefficients of the quarter-wave sine, Q30
  function automatic logic [31:0] sine_coef(input logic [2:0] j);
    logic [31:0] c;
    case (j)
      3'd1: c = 32'd172271;
      3'd2: c = 32'd5026996;
      3'd3: c = 32'd85569272;
      3'd4: c = 32'd693598668;
      3'd5: c = 32'd1686629713;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
    logic signed [31:0] s;
    if (v > 46'sd2147483647) s = 32'sh7FFF_FFFF;
    else if (v < -46'sd2147483648) s = 32'sh8000_0000;
    else s = v[31:0];
    return s;
  endfunction

endpackage

// ===== design/rpvg_mul.sv =====
module rpvg_mul
  import rpvg_pkg::*;
(
  input  logic [MUL_A_W-1:0] op_a,
  input  logic [MUL_B_W-1:0] op_b,
  output logic [MUL_P_W-1:0] prod
);

  assign prod = MUL_P_W'(op_a) * MUL_P_W'(op_b);

endmodule

// ===== design/rpvg_sqrt.sv =====
module rpvg_sqrt
  import rpvg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] num_r, num_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r;
  logic        busy_r, done_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  always_comb begin
    if (num_r >= trial) begin
      num_nxt = num_r - trial;
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      num_nxt = num_r;
      res_nxt = res_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      num_r <= num_nxt;
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

// ===== design/rpvg_div.sv =====
module rpvg_div
  import rpvg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [5:0]  index,
  input  logic [6:0]  sides,
  output logic        done,
  output logic [31:0] phase
);

  logic [6:0]  rem_r;
  logic [6:0]  den_r;
  logic [31:0] quo_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [6:0]  rem_sh;
  logic        take;

  // remainder stays below the side count, so the doubled value fits 7 bits
  assign rem_sh = {rem_r[5:0], 1'b0};
  assign take   = rem_sh >= den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, index};
      den_r <= sides;
      quo_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? rem_sh - den_r : rem_sh;
      quo_r <= {quo_r[30:0], take};
      cnt_r <= cnt_r + 5'd1;
    end
  end

  assign done  = done_r;
  assign phase = quo_r;

endmodule

// ===== design/regular_polygon_vertex_generator.sv =====
// From accept to the first vertex: two squares, a 32-step root and a 32-step phase divide;
// then, per vertex, a 32-step phase divide, 14 sine steps and four products through one
// shared multiplier. One request at a time; in_stall stays high until the last vertex is
// loaded out. Reset (synchronous, rst_n low) returns to idle, drops any pending vertex and
// sets grid_scale to 1.0 and both screen origins to 0.
module regular_polygon_vertex_generator
  import rpvg_pkg::*;
#(
  parameter int MAX_SIDES = MAX_SIDES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [6:0] MAX_N = 7'(MAX_SIDES);

  state_t state_r, state_nxt;

  logic [15:0]        scale_r;
  logic signed [31:0] org_x_r, org_y_r;

  logic signed [31:0] cx_r, cy_r;
  logic [31:0]        a_r, b_r;
  logic               halve_r;
  logic [6:0]         n_r;
  logic [5:0]         i_r;
  logic [63:0]        ssq_r;
  logic [32:0]        rad_r;
  logic [31:0]        ph_r;
  logic [3:0]         k_r;
  logic [30:0]        t2_r;
  logic [31:0]        p_r;
  logic [30:0]        sf_r, cf_r;
  logic signed [35:0] gx_r, gy_r;
  logic signed [52:0] scx_r, scy_r;
  out_item_t          out_r;
  logic               out_valid_r;

  logic [MUL_A_W-1:0] op_a;
  logic [MUL_B_W-1:0] op_b;
  logic [MUL_P_W-1:0] prod;

  logic        sq_start, sq_done, dv_start, dv_done;
  logic [31:0] root, phase;
  logic [5:0]  dv_index;

  logic               accept;
  logic signed [32:0] dx, dy;
  logic [32:0]        ma, mb;
  logic [6:0]         n_cl;
  logic               big;

  logic        half;
  logic [2:0]  j;
  logic [30:0] t_cur, f_cmp;
  logic [1:0]  quad;
  logic [30:0] cm, sm;
  logic        cneg, sneg;
  logic [63:0] off_sum;
  logic [33:0] off;
  logic signed [35:0] gsel;
  logic [34:0] gmag;
  logic signed [52:0] sprod;
  logic signed [44:0] tx, ty;
  logic        out_free, last;

  rpvg_mul u_mul (.op_a(op_a), .op_b(op_b), .prod(prod));

  rpvg_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .num(ssq_r + prod[63:0]), .done(sq_done), .root(root)
  );

  rpvg_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .index(dv_index),
    .sides(n_r), .done(dv_done), .phase(phase)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = state_r != ST_IDLE;
  assign out_free = !out_valid_r || !out_stall;
  assign last     = {1'b0, i_r} == n_r - 7'd1;

  assign dx   = 33'(in_data.corner_x) - 33'(in_data.center_x);
  assign dy   = 33'(in_data.corner_y) - 33'(in_data.center_y);
  assign ma   = dx[32] ? 33'(-dx) : 33'(dx);
  assign mb   = dy[32] ? 33'(-dy) : 33'(dy);
  assign big  = ma[32] | ma[31] | mb[32] | mb[31];
  assign n_cl = (in_data.side_count > MAX_N) ? MAX_N : in_data.side_count;

  assign half  = k_r >= 4'd7;
  assign j     = half ? 3'(k_r - 4'd7) : k_r[2:0];
  assign f_cmp = Q30_ONE - {1'b0, ph_r[29:0]};
  assign t_cur = half ? f_cmp : {1'b0, ph_r[29:0]};
  assign quad  = ph_r[31:30];

  always_comb begin
    case (quad)
      2'd0: begin cm = cf_r; cneg = 1'b0; sm = sf_r; sneg = 1'b0; end
      2'd1: begin cm = sf_r; cneg = 1'b1; sm = cf_r; sneg = 1'b0; end
      2'd2: begin cm = cf_r; cneg = 1'b1; sm = sf_r; sneg = 1'b1; end
      default: begin cm = sf_r; cneg = 1'b0; sm = cf_r; sneg = 1'b1; end
    endcase
  end

  assign gsel  = (state_r == ST_SCX) ? gx_r : gy_r;
  assign gmag  = gsel[35] ? 35'(-gsel) : 35'(gsel);
  assign sprod = gsel[35] ? -$signed({1'b0, prod[51:0]}) : $signed({1'b0, prod[51:0]});

  // round to nearest quarter-turn product, offset = (r*m + 2^29) >> 30
  assign off_sum = prod[63:0] + 64'h2000_0000;
  assign off     = off_sum[63:30];

  assign tx = 45'((scx_r + 53'sd128) >>> 8);
  assign ty = 45'((scy_r + 53'sd128) >>> 8);

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      ST_SQA: begin op_a = 35'(a_r); op_b = 33'(a_r); end
      ST_SQB: begin op_a = 35'(b_r); op_b = 33'(b_r); end
      ST_TRIG: begin
        if (j == 3'd0) begin
          op_a = 35'(t_cur); op_b = 33'(t_cur);
        end else if (j == 3'd6) begin
          op_a = 35'(t_cur); op_b = 33'(p_r);
        end else begin
          op_a = 35'(t2_r); op_b = 33'(p_r);
        end
      end
      ST_OFFX: begin op_a = 35'(cm); op_b = rad_r; end
      ST_OFFY: begin op_a = 35'(sm); op_b = rad_r; end
      ST_SCX, ST_SCY: begin op_a = gmag; op_b = 33'(scale_r); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    dv_index  = '0;
    case (state_r)
      ST_IDLE: if (accept && n_cl != 7'd0) state_nxt = ST_SQA;
      ST_SQA:  state_nxt = ST_SQB;
      ST_SQB: begin
        sq_start  = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: if (sq_done) begin
        dv_start  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV:  if (dv_done) state_nxt = ST_TRIG;
      ST_TRIG: if (k_r == 4'd13) state_nxt = ST_OFFX;
      ST_OFFX: state_nxt = ST_OFFY;
      ST_OFFY: state_nxt = ST_SCX;
      ST_SCX:  state_nxt = ST_SCY;
      ST_SCY:  state_nxt = ST_EMIT;
      ST_EMIT: if (out_free) begin
        if (last) begin
          state_nxt = ST_IDLE;
        end else begin
          dv_start  = 1'b1;
          dv_index  = i_r + 6'd1;
          state_nxt = ST_DIV;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      scale_r     <= GRID_SCALE_RST;
      org_x_r     <= '0;
      org_y_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_SCALE: scale_r <= cfg_data[15:0];
          REG_ORIGIN_X:   org_x_r <= cfg_data;
          REG_ORIGIN_Y:   org_y_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_EMIT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (accept) begin
        cx_r    <= in_data.center_x;
        cy_r    <= in_data.center_y;
        a_r     <= big ? ma[32:1] : ma[31:0];
        b_r     <= big ? mb[32:1] : mb[31:0];
        halve_r <= big;
        n_r     <= n_cl;
      end
      ST_SQA: ssq_r <= prod[63:0];
      ST_ROOT: begin
        rad_r <= halve_r ? {root, 1'b0} : {1'b0, root};
        i_r   <= '0;
      end
      ST_DIV: begin
        ph_r <= phase;
        k_r  <= '0;
      end
      ST_TRIG: begin
        k_r <= k_r + 4'd1;
        if (j == 3'd0) begin
          t2_r <= prod[60:30];
          p_r  <= SINE_SEED;
        end else if (j == 3'd6) begin
          if (prod[61:30] > 32'(Q30_ONE)) begin
            if (half) cf_r <= Q30_ONE; else sf_r <= Q30_ONE;
          end else begin
            if (half) cf_r <= prod[60:30]; else sf_r <= prod[60:30];
          end
        end else begin
          p_r <= sine_coef(j) - prod[61:30];
        end
      end
      ST_OFFX: gx_r <= 36'(cx_r) + (cneg ? -$signed({2'b0, off}) : $signed({2'b0, off}));
      ST_OFFY: gy_r <= 36'(cy_r) + (sneg ? -$signed({2'b0, off}) : $signed({2'b0, off}));
      ST_SCX:  scx_r <= sprod;
      ST_SCY:  scy_r <= sprod;
      ST_EMIT: if (out_free) begin
        out_r.vertex_x     <= sat32(46'(org_x_r) + 46'(tx));
        out_r.vertex_y     <= sat32(46'(org_y_r) - 46'(ty));
        out_r.vertex_index <= i_r;
        out_r.last_vertex  <= last;
        if (!last) i_r <= i_r + 6'd1;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== verif/tb_regular_polygon_vertex_generator.sv =====
module tb_regular_polygon_vertex_generator;
  import rpvg_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_GRID_SCALE;
  logic [31:0] cfg_data = '0;

  regular_polygon_vertex_generator dut (.*);

  always #5 clk = ~clk;

  // shadow copies of the screen mapping registers
  logic [15:0]        scale_q;
  logic signed [31:0] org_x_q;
  logic signed [31:0] org_y_q;

  in_item_t  request_q[$];
  out_item_t vertex_q[$];
  int        errors = 0;
  int        n_vertices = 0;
  int        n_requests = 0;
  bit        hold_off = 1'b0;
  bit        hold_req = 1'b0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] num);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > num) b = b >> 2;
    while (b != 0) begin
      if (num >= res + b) begin
        num = num - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] q30_sine(input logic [63:0] t);
    logic [63:0] t2, p;
    t2 = (t * t) >> 30;
    p = 3864;
    p = 172271 - ((t2 * p) >> 30);
    p = 5026996 - ((t2 * p) >> 30);
    p = 85569272 - ((t2 * p) >> 30);
    p = 693598668 - ((t2 * p) >> 30);
    p = 1686629713 - ((t2 * p) >> 30);
    p = (t * p) >> 30;
    return (p > 64'd1073741824) ? 64'd1073741824 : p;
  endfunction

  function automatic longint floor_div256(input longint v);
    return (v >= 0) ? (v >>> 8) : -((-v + 255) >>> 8);
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint rounded_offset(input logic [63:0] r, input logic [63:0] m,
                                            input bit neg);
    longint o;
    o = longint'((r * m + (64'd1 << 29)) >> 30);
    return neg ? -o : o;
  endfunction

  task automatic predict_vertices(input in_item_t req);
    longint cx, cy, dx, dy, gx, gy;
    logic [63:0] a, b, r, ph, f, sf, cf, sm, cm;
    int n;
    bit sneg, cneg;
    out_item_t v;
    cx = req.center_x;
    cy = req.center_y;
    dx = longint'(req.corner_x) - cx;
    dy = longint'(req.corner_y) - cy;
    a = (dx < 0) ? -dx : dx;
    b = (dy < 0) ? -dy : dy;
    n = (req.side_count > 64) ? 64 : req.side_count;
    if (a >= 64'd1 << 31 || b >= 64'd1 << 31) begin
      a = a >> 1;
      b = b >> 1;
      r = int_sqrt(a * a + b * b) << 1;
    end else begin
      r = int_sqrt(a * a + b * b);
    end
    for (int i = 0; i < n; i++) begin
      ph = (64'(i) << 32) / n;
      f = ph & 64'h3FFF_FFFF;
      sf = q30_sine(f);
      cf = q30_sine(64'd1073741824 - f);
      case (ph[31:30])
        2'd0: begin sm = sf; sneg = 0; cm = cf; cneg = 0; end
        2'd1: begin sm = cf; sneg = 0; cm = sf; cneg = 1; end
        2'd2: begin sm = sf; sneg = 1; cm = cf; cneg = 1; end
        default: begin sm = cf; sneg = 1; cm = sf; cneg = 0; end
      endcase
      gx = cx + rounded_offset(r, cm, cneg);
      gy = cy + rounded_offset(r, sm, sneg);
      v.vertex_x = clamp32(longint'(org_x_q) + floor_div256(gx * scale_q + 128));
      v.vertex_y = clamp32(longint'(org_y_q) - floor_div256(gy * scale_q + 128));
      v.vertex_index = i[5:0];
      v.last_vertex = (i == n - 1);
      vertex_q.insert(vertex_q.size(), v);
    end
  endtask

  // driver: bursts of items with random gaps
  int burst_left = 0;
  int gap_left = 0;
  bit in_taken = 1'b0;

  always @(posedge clk) in_taken <= rst_n && in_valid && !in_stall;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_taken) predict_vertices(in_data);
      if (request_q.size() > 0 && gap_left == 0) begin
        in_valid <= 1'b1;
        in_data <= request_q.pop_front();
        if (burst_left == 0) begin
          burst_left = $urandom_range(8, 1);
          gap_left = $urandom_range(3) == 0 ? 0 : $urandom_range(40, 1);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // receiver stall pattern plus one long hold-off counted here
  int stall_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = 6000;
      hold_done = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    hold_off = (hold_left > 0);
    if ($urandom_range(63) == 0) stall_mode = $urandom_range(2);
    case (stall_mode)
      0: out_stall <= hold_off;
      1: out_stall <= hold_off || ($urandom_range(3) == 0);
      default: out_stall <= hold_off || ($urandom_range(1) == 0);
    endcase
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (vertex_q.size() == 0) begin
        $error("vertex with no expectation: %p", out_data);
        errors++;
      end else begin
        e = vertex_q.pop_front();
        n_vertices++;
        if (out_data.vertex_x !== e.vertex_x) begin
          $error("vertex_x exp %0d got %0d", e.vertex_x, out_data.vertex_x); errors++;
        end
        if (out_data.vertex_y !== e.vertex_y) begin
          $error("vertex_y exp %0d got %0d", e.vertex_y, out_data.vertex_y); errors++;
        end
        if (out_data.vertex_index !== e.vertex_index) begin
          $error("vertex_index exp %0d got %0d", e.vertex_index, out_data.vertex_index);
          errors++;
        end
        if (out_data.last_vertex !== e.last_vertex) begin
          $error("last_vertex exp %0d got %0d", e.last_vertex, out_data.last_vertex);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_GRID_SCALE: scale_q = val[15:0];
      REG_ORIGIN_X:   org_x_q = val;
      default:        org_y_q = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_request(input logic [31:0] cx, cy, kx, ky, input logic [6:0] n);
    in_item_t r;
    r.center_x = cx; r.center_y = cy; r.corner_x = kx; r.corner_y = ky;
    r.side_count = n;
    request_q.insert(request_q.size(), r);
    n_requests++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) << 16;
      default: return 32'($signed($urandom_range(200000)) - 100000) << 4;
    endcase
  endfunction

  task automatic random_requests(input int count);
    logic [31:0] cx, cy;
    logic [6:0] n;
    for (int k = 0; k < count; k++) begin
      cx = rand_coord();
      cy = rand_coord();
      n = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(12));
      add_request(cx, cy, ($urandom_range(4) == 0) ? rand_coord()
                                                   : cx + ($urandom_range(1 << 22) - (1 << 21)),
                  cy + ($urandom_range(1 << 22) - (1 << 21)), n);
    end
  endtask

  // wait for all results, then for a cycle margin in case a request was still working
  task automatic drain();
    wait (request_q.size() == 0 && !in_valid);
    wait (vertex_q.size() == 0 && !in_stall);
    repeat (3500) @(posedge clk);
  endtask

  initial begin
    scale_q = GRID_SCALE_RST;
    org_x_q = 0;
    org_y_q = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero sides, clamping of side count, tiny radius
    add_request(32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0006_0000, 7'd4);
    add_request(0, 0, 0, 0, 7'd0);
    add_request(0, 0, 32'h0001_0000, 0, 7'd1);
    add_request(0, 0, 32'h0001_0000, 0, 7'd2);
    add_request(0, 0, 32'h0001_0000, 0, 7'd3);
    add_request(0, 0, 32'h0003_0000, 32'h0004_0000, 7'd64);
    add_request(0, 0, 32'h0001_0000, 0, 7'd127);
    add_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 7'd5);
    add_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 7'd6);
    add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 7'd8);
    add_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd3);
    add_request(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 7'd65);
    drain();

    write_reg(REG_GRID_SCALE, 32'd0);
    write_reg(REG_ORIGIN_X, 32'h0100_0000);
    write_reg(REG_ORIGIN_Y, 32'hFF00_0000);
    add_request(0, 0, 32'h0010_0000, 0, 7'd4);
    random_requests(10);
    drain();

    write_reg(REG_GRID_SCALE, 32'hFFFF);
    write_reg(REG_ORIGIN_X, 32'h7FFF_FFFF);
    write_reg(REG_ORIGIN_Y, 32'h8000_0000);
    random_requests(15);
    drain();

    write_reg(REG_GRID_SCALE, 32'd1);
    write_reg(REG_ORIGIN_X, 32'h8000_0000);
    write_reg(REG_ORIGIN_Y, 32'h7FFF_FFFF);
    random_requests(15);
    // long receiver hold-off while requests keep coming
    hold_req = 1'b1;
    wait (hold_done && !hold_off);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_GRID_SCALE, $urandom_range(65535, 1));
      write_reg(REG_ORIGIN_X, $urandom);
      write_reg(REG_ORIGIN_Y, $urandom);
      random_requests(20);
      drain();
    end

    $display("Sent %0d polygon requests, checked %0d vertices over eight register settings",
             n_requests, n_vertices);
    if (errors == 0 && vertex_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
